// File: rtl/z80_alu_with_flags_macros.svh
// assertion macros used by the port-level checker file
`ifndef Z80_ALU_WITH_FLAGS_MACROS_SVH
`define Z80_ALU_WITH_FLAGS_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ZALU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zalu assertion failed");

// next-cycle implication, disabled while reset is low
`define ZALU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zalu assertion failed");

`endif

// File: rtl/zalu_pkg.sv
// types, operation codes and flag helpers for the z80 alu
package zalu_pkg;

    localparam logic [4:0] K_INC     = 5'd0;
    localparam logic [4:0] K_DEC     = 5'd1;
    localparam logic [4:0] K_ADD     = 5'd2;
    localparam logic [4:0] K_ADC     = 5'd3;
    localparam logic [4:0] K_SUB     = 5'd4;
    localparam logic [4:0] K_SBC     = 5'd5;
    localparam logic [4:0] K_AND     = 5'd6;
    localparam logic [4:0] K_OR      = 5'd7;
    localparam logic [4:0] K_XOR     = 5'd8;
    localparam logic [4:0] K_CP      = 5'd9;
    localparam logic [4:0] K_RLC     = 5'd10;
    localparam logic [4:0] K_RRC     = 5'd11;
    localparam logic [4:0] K_RL      = 5'd12;
    localparam logic [4:0] K_RR      = 5'd13;
    localparam logic [4:0] K_SLA     = 5'd14;
    localparam logic [4:0] K_SRA     = 5'd15;
    localparam logic [4:0] K_SRL     = 5'd16;
    localparam logic [4:0] K_SLL     = 5'd17;
    localparam logic [4:0] K_BIT     = 5'd18;
    localparam logic [4:0] K_BITMP   = 5'd19;
    localparam logic [4:0] K_SET     = 5'd20;
    localparam logic [4:0] K_RES     = 5'd21;
    localparam logic [4:0] K_ADD16   = 5'd22;
    localparam logic [4:0] K_ADC16   = 5'd23;
    localparam logic [4:0] K_SBC16   = 5'd24;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [7:0]  flags_in;
        logic [2:0]  bit_index;
        logic [15:0] memptr_in;
    } t_alu_in;

    typedef struct packed {
        logic [15:0] result;
        logic [7:0]  flags_out;
        logic [15:0] memptr_out;
    } t_alu_out;

    // sign, zero, f5 and f3 of a byte
    function automatic logic [7:0] f_sz35(input logic [7:0] v);
        f_sz35 = {v[7], (v == 8'h00), v[5], 1'b0, v[3], 3'b000};
    endfunction

    // even parity in the p/v position
    function automatic logic [7:0] f_parity(input logic [7:0] v);
        f_parity = {5'b00000, ~(^v), 2'b00};
    endfunction

endpackage

// File: rtl/zalu_core.sv
// combinational datapath: result, flags and memptr for one word
module zalu_core
    import zalu_pkg::*;
(
    input  t_alu_in  i_item,
    output t_alu_out o_result
);

    logic [7:0]  a8, r8, fin, mask8, res8, f8;
    logic [7:0]  inc8, dec8, sh8, b8e, ar_r8, ar_f8;
    logic [8:0]  sum9;
    logic        sub8, cin8, h8, v8, c8, sh_c;
    logic [15:0] a16, b16, b16e, ar_r16, res16, mpo;
    logic [16:0] sum17;
    logic        sub16, cin16, h16, v16, c16;
    logic        bit_z;

    always_comb begin
        a8    = i_item.operand_a[7:0];
        r8    = i_item.operand_b[7:0];
        fin   = i_item.flags_in;
        a16   = i_item.operand_a;
        b16   = i_item.operand_b;
        mask8 = 8'h01 << i_item.bit_index;
        bit_z = ~|(r8 & mask8);

        // 8-bit add/subtract unit
        sub8  = (i_item.kind == K_SUB) || (i_item.kind == K_SBC) || (i_item.kind == K_CP);
        cin8  = ((i_item.kind == K_ADC) || (i_item.kind == K_SBC)) && fin[0];
        b8e   = sub8 ? ~r8 : r8;
        sum9  = {1'b0, a8} + {1'b0, b8e} + {8'h00, sub8 ^ cin8};
        ar_r8 = sum9[7:0];
        c8    = sum9[8] ^ sub8;
        h8    = a8[4] ^ r8[4] ^ ar_r8[4];
        v8    = sub8 ? ((a8[7] ^ r8[7]) & (a8[7] ^ ar_r8[7]))
                     : (~(a8[7] ^ r8[7]) & (a8[7] ^ ar_r8[7]));
        ar_f8 = {ar_r8[7], (ar_r8 == 8'h00), ar_r8[5], h8, ar_r8[3], v8, sub8, c8};

        // 16-bit add/subtract unit
        sub16  = (i_item.kind == K_SBC16);
        cin16  = ((i_item.kind == K_ADC16) || (i_item.kind == K_SBC16)) && fin[0];
        b16e   = sub16 ? ~b16 : b16;
        sum17  = {1'b0, a16} + {1'b0, b16e} + {16'h0000, sub16 ^ cin16};
        ar_r16 = sum17[15:0];
        c16    = sum17[16] ^ sub16;
        h16    = a16[12] ^ b16[12] ^ ar_r16[12];
        v16    = sub16 ? ((a16[15] ^ b16[15]) & (a16[15] ^ ar_r16[15]))
                       : (~(a16[15] ^ b16[15]) & (a16[15] ^ ar_r16[15]));

        inc8 = r8 + 8'h01;
        dec8 = r8 - 8'h01;

        // rotate and shift forms
        case (i_item.kind)
            K_RLC:   begin sh8 = {r8[6:0], r8[7]};   sh_c = r8[7]; end
            K_RRC:   begin sh8 = {r8[0], r8[7:1]};   sh_c = r8[0]; end
            K_RL:    begin sh8 = {r8[6:0], fin[0]};  sh_c = r8[7]; end
            K_RR:    begin sh8 = {fin[0], r8[7:1]};  sh_c = r8[0]; end
            K_SLA:   begin sh8 = {r8[6:0], 1'b0};    sh_c = r8[7]; end
            K_SRA:   begin sh8 = {r8[7], r8[7:1]};   sh_c = r8[0]; end
            K_SRL:   begin sh8 = {1'b0, r8[7:1]};    sh_c = r8[0]; end
            default: begin sh8 = {r8[6:0], 1'b1};    sh_c = r8[7]; end
        endcase

        res8  = 8'h00;
        f8    = fin;
        res16 = 16'h0000;
        mpo   = i_item.memptr_in;

        case (i_item.kind)
            K_INC: begin
                res8 = inc8;
                f8   = f_sz35(inc8) | {3'b000, (inc8[3:0] == 4'h0), 1'b0,
                       (inc8 == 8'h80), 1'b0, fin[0]};
            end
            K_DEC: begin
                res8 = dec8;
                f8   = f_sz35(dec8) | {3'b000, (r8[3:0] == 4'h0), 1'b0,
                       (dec8 == 8'h7f), 1'b1, fin[0]};
            end
            K_ADD, K_ADC, K_SUB, K_SBC: begin
                res8 = ar_r8;
                f8   = ar_f8;
            end
            K_AND: begin
                res8 = a8 & r8;
                f8   = f_sz35(a8 & r8) | f_parity(a8 & r8) | 8'h10;
            end
            K_OR: begin
                res8 = a8 | r8;
                f8   = f_sz35(a8 | r8) | f_parity(a8 | r8);
            end
            K_XOR: begin
                res8 = a8 ^ r8;
                f8   = f_sz35(a8 ^ r8) | f_parity(a8 ^ r8);
            end
            K_CP: begin
                res8 = a8;
                f8   = {ar_f8[7:6], r8[5], ar_f8[4], r8[3], ar_f8[2:0]};
            end
            K_RLC, K_RRC, K_RL, K_RR, K_SLA, K_SRA, K_SRL, K_SLL: begin
                res8 = sh8;
                f8   = f_sz35(sh8) | f_parity(sh8) | {7'h00, sh_c};
            end
            K_BIT: begin
                res8 = r8;
                f8   = {(i_item.bit_index == 3'd7) & r8[7], bit_z, r8[5], 1'b1,
                        r8[3], bit_z, 1'b0, fin[0]};
            end
            K_BITMP: begin
                res8 = r8;
                f8   = {(i_item.bit_index == 3'd7) & r8[7], bit_z,
                        i_item.memptr_in[13], 1'b1, i_item.memptr_in[11], bit_z,
                        1'b0, fin[0]};
            end
            K_SET: res8 = r8 | mask8;
            K_RES: res8 = r8 & ~mask8;
            K_ADD16: begin
                res16 = ar_r16;
                f8    = {fin[7:6], ar_r16[13], h16, ar_r16[11], fin[2], 1'b0, c16};
                mpo   = a16 + 16'h0001;
            end
            K_ADC16, K_SBC16: begin
                res16 = ar_r16;
                f8    = {ar_r16[15], (ar_r16 == 16'h0000), ar_r16[13], h16,
                         ar_r16[11], v16, sub16, c16};
                mpo   = a16 + 16'h0001;
            end
            default: begin
                res8 = 8'h00;
                f8   = fin;
            end
        endcase

        o_result.result     = (i_item.kind >= K_ADD16) ? res16 : {8'h00, res8};
        o_result.flags_out  = f8;
        o_result.memptr_out = mpo;
    end

endmodule

// File: rtl/z80_alu_with_flags.sv
// z80 alu top level: input register, flag datapath and result register
// a word taken into the input register is registered again in the result register and then strobed on o_done
// throughput: one word per cycle; busy stays low, so start may be held every cycle
// the path between the two registers is one pass through the 8/16-bit adder and flag logic
// reset: synchronous, active low; clears the valid bits of both stages, payload is kept
module z80_alu_with_flags
    import zalu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_alu_in  i_item,
    output logic     o_done,
    output t_alu_out o_result
);

    t_alu_in  r_in;
    logic     r_in_vld, n_in_vld;
    t_alu_out r_out, n_out;
    logic     r_out_vld, n_out_vld;

    zalu_core u_core (
        .i_item   (r_in),
        .o_result (n_out)
    );

    assign busy      = 1'b0;
    assign n_in_vld  = start & ~busy;
    assign n_out_vld = r_in_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_in_vld) begin
            r_in <= i_item;
        end
        if (n_out_vld) begin
            r_out <= n_out;
        end
    end

    assign o_done   = r_out_vld;
    assign o_result = r_out;

endmodule

// File: rtl/zalu_checker.sv
// port-level checker for the z80 alu, bound to the top level
`include "z80_alu_with_flags_macros.svh"

module zalu_checker
    import zalu_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input t_alu_in  i_item,
    input logic     o_done,
    input t_alu_out o_result
);

    `ZALU_ASSERT_NOW(a_no_stall, i_clk, i_rst_n, 1'b1, !busy)
    `ZALU_ASSERT_NEXT(a_word_out, i_clk, i_rst_n, start && !busy, ##1 o_done)
    `ZALU_ASSERT_NOW(a_no_spurious, i_clk, i_rst_n, o_done, $past(start && !busy, 2))
    `ZALU_ASSERT_NOW(a_memptr16, i_clk, i_rst_n, o_done && ($past(i_item.kind, 2) == K_ADD16 || $past(i_item.kind, 2) == K_ADC16 || $past(i_item.kind, 2) == K_SBC16), o_result.memptr_out == 16'($past(i_item.operand_a, 2) + 16'h0001))

endmodule

bind z80_alu_with_flags zalu_checker u_zalu_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_done   (o_done),
    .o_result (o_result)
);

// File: verif/z80_alu_with_flags_tb_pkg.sv
// scoreboard class and flag constants for the z80 alu testbench
`timescale 1ns / 1ps
package z80_alu_with_flags_tb_pkg;
    import zalu_pkg::*;

    localparam int FB_S  = 7;
    localparam int FB_Z  = 6;
    localparam int FB_5  = 5;
    localparam int FB_H  = 4;
    localparam int FB_3  = 3;
    localparam int FB_PV = 2;
    localparam int FB_N  = 1;
    localparam int FB_C  = 0;

    localparam logic [4:0] K_UNUSED_LO = 5'd25;
    localparam logic [4:0] K_UNUSED_HI = 5'd31;

    localparam int MAX_REPORTS = 10;

    class alu_word_checker;
        t_alu_out    expected_words[$];
        logic [31:0] kinds_seen;
        int          n_noted;
        int          n_checked;
        int          n_mismatch;
        int          n_unexpected;

        function new();
            kinds_seen   = '0;
            n_noted      = 0;
            n_checked    = 0;
            n_mismatch   = 0;
            n_unexpected = 0;
        endfunction

        // sign, zero and the two undocumented bits of a byte
        function logic [7:0] byte_flags(logic [7:0] v);
            logic [7:0] f;
            f        = 8'h00;
            f[FB_S]  = v[7];
            f[FB_Z]  = (v == 8'h00);
            f[FB_5]  = v[5];
            f[FB_3]  = v[3];
            return f;
        endfunction

        function t_alu_out predict_alu_word(t_alu_in w);
            t_alu_out   o;
            logic [7:0] a, r, res8, f, mask;
            logic [8:0] sum9;
            logic [16:0] sum17;
            logic [15:0] res16;
            logic       cin, carry, sub, c;
            a     = w.operand_a[7:0];
            r     = w.operand_b[7:0];
            cin   = w.flags_in[FB_C];
            f     = w.flags_in;
            res16 = 16'h0000;
            mask  = 8'h01 << w.bit_index;
            o.memptr_out = w.memptr_in;
            case (w.kind)
                K_INC: begin
                    res8      = r + 8'h01;
                    f         = byte_flags(res8);
                    f[FB_C]   = cin;
                    f[FB_PV]  = (res8 == 8'h80);
                    f[FB_H]   = (res8[3:0] == 4'h0);
                    res16     = {8'h00, res8};
                end
                K_DEC: begin
                    res8      = r - 8'h01;
                    f         = byte_flags(res8);
                    f[FB_C]   = cin;
                    f[FB_N]   = 1'b1;
                    f[FB_H]   = (r[3:0] == 4'h0);
                    f[FB_PV]  = (res8 == 8'h7f);
                    res16     = {8'h00, res8};
                end
                K_ADD, K_ADC, K_SUB, K_SBC, K_CP: begin
                    sub   = (w.kind == K_SUB) || (w.kind == K_SBC) || (w.kind == K_CP);
                    carry = ((w.kind == K_ADC) || (w.kind == K_SBC)) ? cin : 1'b0;
                    if (sub) begin
                        sum9 = {1'b0, a} - {1'b0, r} - {8'h00, carry};
                    end else begin
                        sum9 = {1'b0, a} + {1'b0, r} + {8'h00, carry};
                    end
                    res8     = sum9[7:0];
                    f        = byte_flags(res8);
                    f[FB_H]  = a[4] ^ r[4] ^ res8[4];
                    f[FB_C]  = sum9[8];
                    f[FB_N]  = sub;
                    f[FB_PV] = sub ? ((a[7] ^ r[7]) & (a[7] ^ res8[7]))
                                   : (~(a[7] ^ r[7]) & (a[7] ^ res8[7]));
                    if (w.kind == K_CP) begin
                        f[FB_5] = r[5];
                        f[FB_3] = r[3];
                        res16   = {8'h00, a};
                    end else begin
                        res16   = {8'h00, res8};
                    end
                end
                K_AND, K_OR, K_XOR: begin
                    res8     = (w.kind == K_AND) ? (a & r) : (w.kind == K_OR) ? (a | r) : (a ^ r);
                    f        = byte_flags(res8);
                    f[FB_PV] = ~(^res8);
                    f[FB_H]  = (w.kind == K_AND);
                    res16    = {8'h00, res8};
                end
                K_RLC, K_RRC, K_RL, K_RR, K_SLA, K_SRA, K_SRL, K_SLL: begin
                    case (w.kind)
                        K_RLC:   begin c = r[7]; res8 = {r[6:0], r[7]}; end
                        K_RRC:   begin c = r[0]; res8 = {r[0], r[7:1]}; end
                        K_RL:    begin c = r[7]; res8 = {r[6:0], cin}; end
                        K_RR:    begin c = r[0]; res8 = {cin, r[7:1]}; end
                        K_SLA:   begin c = r[7]; res8 = {r[6:0], 1'b0}; end
                        K_SRA:   begin c = r[0]; res8 = {r[7], r[7:1]}; end
                        K_SRL:   begin c = r[0]; res8 = {1'b0, r[7:1]}; end
                        default: begin c = r[7]; res8 = {r[6:0], 1'b1}; end
                    endcase
                    f        = byte_flags(res8);
                    f[FB_PV] = ~(^res8);
                    f[FB_C]  = c;
                    res16    = {8'h00, res8};
                end
                K_BIT, K_BITMP: begin
                    res16   = {8'h00, r};
                    f       = 8'h00;
                    f[FB_C] = cin;
                    f[FB_H] = 1'b1;
                    if (w.kind == K_BIT) begin
                        f[FB_5] = r[5];
                        f[FB_3] = r[3];
                    end else begin
                        f[FB_5] = w.memptr_in[13];
                        f[FB_3] = w.memptr_in[11];
                    end
                    f[FB_Z]  = ((r & mask) == 8'h00);
                    f[FB_PV] = ((r & mask) == 8'h00);
                    f[FB_S]  = (w.bit_index == 3'd7) && r[7];
                end
                K_SET: res16 = {8'h00, r | mask};
                K_RES: res16 = {8'h00, r & ~mask};
                K_ADD16: begin
                    sum17    = {1'b0, w.operand_a} + {1'b0, w.operand_b};
                    res16    = sum17[15:0];
                    f        = w.flags_in & 8'hc4;
                    f[FB_H]  = w.operand_a[12] ^ w.operand_b[12] ^ res16[12];
                    f[FB_C]  = sum17[16];
                    f[FB_5]  = res16[13];
                    f[FB_3]  = res16[11];
                    o.memptr_out = w.operand_a + 16'h0001;
                end
                K_ADC16, K_SBC16: begin
                    sub = (w.kind == K_SBC16);
                    if (sub) begin
                        sum17 = {1'b0, w.operand_a} - {1'b0, w.operand_b} - {16'h0000, cin};
                    end else begin
                        sum17 = {1'b0, w.operand_a} + {1'b0, w.operand_b} + {16'h0000, cin};
                    end
                    res16    = sum17[15:0];
                    f        = byte_flags(res16[15:8]);
                    f[FB_Z]  = (res16 == 16'h0000);
                    f[FB_H]  = w.operand_a[12] ^ w.operand_b[12] ^ res16[12];
                    f[FB_C]  = sum17[16];
                    f[FB_N]  = sub;
                    f[FB_PV] = sub
                        ? ((w.operand_a[15] ^ w.operand_b[15]) & (w.operand_a[15] ^ res16[15]))
                        : (~(w.operand_a[15] ^ w.operand_b[15]) & (w.operand_a[15] ^ res16[15]));
                    o.memptr_out = w.operand_a + 16'h0001;
                end
                default: begin
                    res16 = 16'h0000;
                    f     = w.flags_in;
                end
            endcase
            o.result    = res16;
            o.flags_out = f;
            return o;
        endfunction

        function void note_word(t_alu_in w);
            expected_words.push_back(predict_alu_word(w));
            kinds_seen[w.kind] = 1'b1;
            n_noted++;
        endfunction

        function void check_word(t_alu_out got);
            t_alu_out want;
            if (expected_words.size() == 0) begin
                n_unexpected++;
                if (n_mismatch + n_unexpected <= MAX_REPORTS) begin
                    $display("%0t unexpected result word %h", $time, got);
                end
                return;
            end
            want = expected_words.pop_front();
            n_checked++;
            if (got.result !== want.result || got.flags_out !== want.flags_out
                || got.memptr_out !== want.memptr_out) begin
                n_mismatch++;
                if (n_mismatch + n_unexpected <= MAX_REPORTS) begin
                    $display("%0t mismatch word %0d: result %h/%h flags %h/%h memptr %h/%h",
                             $time, n_checked, want.result, got.result, want.flags_out,
                             got.flags_out, want.memptr_out, got.memptr_out);
                end
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

endpackage

// File: verif/z80_alu_with_flags_tb.sv
// top-level testbench for the z80 alu: stimulus, monitor and end-of-run check
`timescale 1ns / 1ps
module z80_alu_with_flags_tb;
    import zalu_pkg::*;
    import z80_alu_with_flags_tb_pkg::*;

    localparam int N_RANDOM     = 550;
    localparam int N_TAIL       = 80;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 100000;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_alu_in  i_item;
    logic     o_done;
    t_alu_out o_result;

    int              n_cycles;
    alu_word_checker flag_chk = new();

    z80_alu_with_flags dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && busy === 1'b0) begin
                flag_chk.note_word(i_item);
            end
            if (o_done !== 1'b0) begin
                flag_chk.check_word(o_result);
            end
        end
    end

    function automatic t_alu_in mk_word(logic [4:0] kind, logic [15:0] a, logic [15:0] b,
                                        logic [7:0] fl, logic [2:0] bi, logic [15:0] mp);
        t_alu_in w;
        w.kind      = kind;
        w.operand_a = a;
        w.operand_b = b;
        w.flags_in  = fl;
        w.bit_index = bi;
        w.memptr_in = mp;
        return w;
    endfunction

    // a value at a carry or sign boundary in seven of twelve picks, else fully random
    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 11))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'h7fff;
            3:       return 16'h8000;
            4:       return {8'($urandom), 8'h7f};
            5:       return {8'($urandom), 8'h80};
            6:       return {8'($urandom), 8'hff};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_word(input t_alu_in w);
        start  <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (flag_chk.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        n_cycles = 0;
        while (n_cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            n_cycles++;
        end
        $display("timeout after %0d cycles", n_cycles);
        $display("FAIL");
        $finish;
    end

    initial begin
        t_alu_in w;
        bit      quiet;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corner words for every operation
        send_word(mk_word(K_INC, 16'h0000, 16'h007f, 8'h00, 3'd0, 16'h0000));
        send_word(mk_word(K_DEC, 16'h0000, 16'h0080, 8'hff, 3'd0, 16'h0000));
        send_word(mk_word(K_ADD, 16'h007f, 16'h0001, 8'h00, 3'd0, 16'h0000));
        send_word(mk_word(K_ADC, 16'hffff, 16'hff00, 8'h01, 3'd7, 16'hffff));
        send_word(mk_word(K_SUB, 16'h0080, 16'h0001, 8'h00, 3'd0, 16'h0000));
        send_word(mk_word(K_SBC, 16'h0000, 16'h0000, 8'h01, 3'd0, 16'h0000));
        send_word(mk_word(K_AND, 16'h00ff, 16'h00ff, 8'h00, 3'd0, 16'h0000));
        send_word(mk_word(K_OR,  16'h0000, 16'h0000, 8'hff, 3'd0, 16'h0000));
        send_word(mk_word(K_XOR, 16'h00ff, 16'h0000, 8'h00, 3'd0, 16'h0000));
        send_word(mk_word(K_CP,  16'h0028, 16'h0028, 8'h00, 3'd0, 16'h0000));
        for (int k = K_RLC; k <= K_SLL; k++) begin
            send_word(mk_word(5'(k), 16'h0000, 16'h0081, 8'h01, 3'd0, 16'h0000));
        end
        send_word(mk_word(K_BIT,   16'h0000, 16'h0080, 8'h01, 3'd7, 16'h0000));
        send_word(mk_word(K_BITMP, 16'h0000, 16'h0000, 8'h00, 3'd0, 16'h2800));
        send_word(mk_word(K_SET,   16'h0000, 16'h0000, 8'ha5, 3'd7, 16'h1234));
        send_word(mk_word(K_RES,   16'h0000, 16'h00ff, 8'h5a, 3'd0, 16'h0000));
        send_word(mk_word(K_ADD16, 16'hffff, 16'h0001, 8'hc4, 3'd0, 16'h0000));
        send_word(mk_word(K_ADC16, 16'h7fff, 16'h0000, 8'h01, 3'd0, 16'h0000));
        send_word(mk_word(K_SBC16, 16'h8000, 16'h0001, 8'h00, 3'd0, 16'h0000));
        send_word(mk_word(K_UNUSED_HI, 16'hffff, 16'hffff, 8'h3c, 3'd7, 16'hbeef));
        drain_results();

        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                w.kind = 5'($urandom_range(K_UNUSED_LO, K_UNUSED_HI));
            end else begin
                w.kind = 5'($urandom_range(K_INC, K_SBC16));
            end
            w.operand_a = pick16();
            w.operand_b = pick16();
            w.flags_in  = 8'($urandom);
            w.bit_index = 3'($urandom);
            w.memptr_in = pick16();
            send_word(w);
            if (i == N_RANDOM / 2) begin
                drain_results();
            end
            quiet = ((i / 40) % 3 == 2) || (i >= N_RANDOM - N_TAIL);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                pause_sender($urandom_range(1, 14));
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d of %0d words over %0d operation codes, %0d mismatching",
                 flag_chk.n_checked, flag_chk.n_noted, $countones(flag_chk.kinds_seen),
                 flag_chk.n_mismatch);
        $display("%0d unexpected words, %0d still awaited", flag_chk.n_unexpected,
                 flag_chk.pending());
        if (flag_chk.n_mismatch == 0 && flag_chk.n_unexpected == 0
            && flag_chk.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
